>>> src/svp_pkg.sv
// Shared constants, types and codes of the smooth velocity profile block.
package svp_pkg;

    // Fixed-point format and derived widths
    localparam int FRAC_BITS = 16;
    localparam int WORD      = 32;
    localparam int XW        = WORD + FRAC_BITS + 1;      // ramp time x = (v << (F+1)) / a
    localparam int TW        = XW + 1;                    // total time tm = d/v + x
    localparam int CRW       = 2 * WORD - FRAC_BITS - 1;  // cruise = (a*x mod 2^64) >> (F+1)
    localparam int NUMW      = 3 * WORD;                  // a * s^2
    localparam int DENW      = XW + FRAC_BITS;            // x << F
    localparam int REMW      = DENW + WORD;               // (x << F) << 32
    localparam int CNTW      = $clog2(XW + 1);
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VELOCITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL    = 2'd2;

    // Reset values of the registers
    localparam logic [WORD-1:0] DISTANCE_RST = WORD'(4) << FRAC_BITS;
    localparam logic [WORD-1:0] VELOCITY_RST = WORD'(1) << FRAC_BITS;
    localparam logic [WORD-1:0] ACCEL_RST    = WORD'(1) << FRAC_BITS;

    // Profile setup sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_SQRT,
        ST_CHK,
        ST_DIVX,
        ST_DIVT,
        ST_CRU1,
        ST_CRU2
    } t_setup_state;

    // Profile segment of a sample
    typedef enum logic [2:0] {
        SEG_NONE,
        SEG_RISE,
        SEG_APPROACH,
        SEG_CRUISE,
        SEG_FALL,
        SEG_TAIL
    } t_seg;

    // Move constants handed from setup to the sample pipeline
    typedef struct packed {
        logic             ok;
        logic             vzero;
        logic [WORD-1:0]  accel;
        logic [XW-1:0]    x;
        logic [XW-1:0]    half;
        logic [TW-1:0]    tm;
        logic [TW-1:0]    tm_x;
        logic [TW-1:0]    tm_half;
        logic [CRW-1:0]   cruise;
    } t_profile;

    // One divider stage of the square term
    typedef struct packed {
        t_seg              seg;
        logic              sat;
        logic [NUMW-1:0]   rem;
        logic [WORD-1:0]   q;
    } t_div;

endpackage

>>> src/svp_stream_if.sv
// Item channels of the smooth velocity profile block.
interface svp_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [svp_pkg::WORD-1:0]  sample_time;

    modport source (output valid, output sample_time, input ready);
    modport sink   (input valid, input sample_time, output ready);
endinterface

interface svp_out_if;
    logic                      valid;
    logic                      ready;
    logic [svp_pkg::WORD-1:0]  velocity;

    modport source (output valid, output velocity, input ready);
    modport sink   (input valid, input velocity, output ready);
endinterface

>>> src/svp_setup.sv
// Sequential unit that derives the move constants from the configuration.
module svp_setup (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [svp_pkg::WORD-1:0] i_dist,
    input  logic [svp_pkg::WORD-1:0] i_vel,
    input  logic [svp_pkg::WORD-1:0] i_accel,
    output svp_pkg::t_profile       o_prof
);
    localparam int WORD = svp_pkg::WORD;
    localparam int XW   = svp_pkg::XW;
    localparam int TW   = svp_pkg::TW;
    localparam int CRW  = svp_pkg::CRW;
    localparam int CNTW = svp_pkg::CNTW;
    localparam int F    = svp_pkg::FRAC_BITS;
    localparam int PADT = XW - WORD - F;

    svp_pkg::t_setup_state r_state, n_state;

    logic [2*WORD-1:0] r_da, r_vv;
    logic [2*WORD-2:0] r_sqn;
    logic [2*WORD-1:0] r_res, r_bit;
    logic [WORD-1:0]   r_v;
    logic [CNTW-1:0]   r_cnt;
    logic [XW-1:0]     r_num, r_quo;
    logic [WORD-1:0]   r_den, r_rem;
    logic [XW-1:0]     r_x, r_half;
    logic [TW-1:0]     r_tm, r_tmx, r_tmh;
    logic [2*WORD-1:0] r_cru0, r_cru1;
    logic [CRW-1:0]    r_cruise;

    logic              w_short;
    logic [2*WORD-1:0] w_trial, w_res_nx;
    logic              w_take;
    logic [WORD:0]     w_shift;
    logic              w_ge;
    logic [WORD-1:0]   w_rem_nx;
    logic [XW-1:0]     w_quo_nx;
    logic [2*WORD-1:0] w_ax;

    // Short move test and square root digit step
    always_comb begin
        w_short  = {1'b0, r_da[2*WORD-1:1]} < r_vv;
        w_trial  = r_res + r_bit;
        w_take   = {1'b0, r_sqn} >= w_trial;
        w_res_nx = w_take ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    end

    // Restoring divider, one quotient bit a cycle
    always_comb begin
        w_shift  = {r_rem, r_num[XW-1]};
        w_ge     = w_shift >= {1'b0, r_den};
        w_rem_nx = w_ge ? WORD'(w_shift - {1'b0, r_den}) : w_shift[WORD-1:0];
        w_quo_nx = {r_quo[XW-2:0], w_ge};
        w_ax     = r_cru0 + {r_cru1[WORD-1:0], {WORD{1'b0}}};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        if (i_start) begin
            n_state = svp_pkg::ST_MUL;
        end else begin
            unique case (r_state)
                svp_pkg::ST_IDLE: n_state = svp_pkg::ST_IDLE;
                svp_pkg::ST_MUL:  n_state = svp_pkg::ST_CMP;
                svp_pkg::ST_CMP:  n_state = w_short ? svp_pkg::ST_SQRT : svp_pkg::ST_CHK;
                svp_pkg::ST_SQRT: if (r_cnt == CNTW'(1)) n_state = svp_pkg::ST_CHK;
                svp_pkg::ST_CHK:  n_state = (r_v == '0) ? svp_pkg::ST_IDLE : svp_pkg::ST_DIVX;
                svp_pkg::ST_DIVX: if (r_cnt == CNTW'(1)) n_state = svp_pkg::ST_DIVT;
                svp_pkg::ST_DIVT: if (r_cnt == CNTW'(1)) n_state = svp_pkg::ST_CRU1;
                svp_pkg::ST_CRU1: n_state = svp_pkg::ST_CRU2;
                svp_pkg::ST_CRU2: n_state = svp_pkg::ST_IDLE;
                default:          n_state = svp_pkg::ST_MUL;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svp_pkg::ST_MUL;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath of the sequencer
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            svp_pkg::ST_MUL: begin
                r_da <= {{WORD{1'b0}}, i_dist} * {{WORD{1'b0}}, i_accel};
                r_vv <= {{WORD{1'b0}}, i_vel} * {{WORD{1'b0}}, i_vel};
            end
            svp_pkg::ST_CMP: begin
                r_v   <= i_vel;
                r_sqn <= r_da[2*WORD-1:1];
                r_res <= '0;
                r_bit <= {2'b01, {(2*WORD-2){1'b0}}};
                r_cnt <= CNTW'(WORD);
            end
            svp_pkg::ST_SQRT: begin
                if (w_take) begin
                    r_sqn <= r_sqn - w_trial[2*WORD-2:0];
                end
                r_res <= w_res_nx;
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_v <= w_res_nx[WORD-1:0];
                end
            end
            svp_pkg::ST_CHK: begin
                r_num <= {r_v, {(F + 1){1'b0}}};
                r_den <= i_accel;
                r_rem <= '0;
                r_quo <= '0;
                r_cnt <= CNTW'(XW);
            end
            svp_pkg::ST_DIVX, svp_pkg::ST_DIVT: begin
                if (r_state == svp_pkg::ST_DIVX && r_cnt == CNTW'(1)) begin
                    // ramp time done, start d << F over the velocity
                    r_x   <= w_quo_nx;
                    r_num <= {{PADT{1'b0}}, i_dist, {F{1'b0}}};
                    r_den <= r_v;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= CNTW'(XW);
                end else begin
                    r_num <= r_num << 1;
                    r_rem <= w_rem_nx;
                    r_quo <= w_quo_nx;
                    r_cnt <= r_cnt - CNTW'(1);
                    if (r_cnt == CNTW'(1)) begin
                        r_tm <= TW'(w_quo_nx) + TW'(r_x);
                    end
                end
            end
            svp_pkg::ST_CRU1: begin
                r_cru0 <= {{WORD{1'b0}}, i_accel} * {{WORD{1'b0}}, r_x[WORD-1:0]};
                r_cru1 <= {{WORD{1'b0}}, i_accel}
                        * {{(2*WORD-XW){1'b0}}, r_x[XW-1:WORD]};
                r_tmx  <= r_tm - TW'(r_x);
                r_half <= r_x >> 1;
            end
            svp_pkg::ST_CRU2: begin
                r_cruise <= w_ax[2*WORD-1:F+1];
                r_tmh    <= r_tm - TW'(r_half);
            end
            default: begin
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_prof.ok      = (r_state == svp_pkg::ST_IDLE);
        o_prof.vzero   = (r_v == '0);
        o_prof.accel   = i_accel;
        o_prof.x       = r_x;
        o_prof.half    = r_half;
        o_prof.tm      = r_tm;
        o_prof.tm_x    = r_tmx;
        o_prof.tm_half = r_tmh;
        o_prof.cruise  = r_cruise;
    end

    a_tm_covers_ramps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_prof.ok && !o_prof.vzero && !$past(i_start) |-> o_prof.tm >= TW'(o_prof.x))
        else $error("total time shorter than ramp time");

    a_sqrt_bit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == svp_pkg::ST_SQRT |-> r_bit != '0)
        else $error("square root ran out of digits");

endmodule

>>> src/svp_pipe.sv
// Sample pipeline: segment select, square term a*s^2/(x*2^F) and result mix.
module svp_pipe (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  svp_pkg::t_profile        i_prof,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [svp_pkg::WORD-1:0] i_time,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [svp_pkg::WORD-1:0] o_vel
);
    localparam int WORD = svp_pkg::WORD;
    localparam int TW   = svp_pkg::TW;
    localparam int NUMW = svp_pkg::NUMW;
    localparam int REMW = svp_pkg::REMW;
    localparam int CRW  = svp_pkg::CRW;
    localparam int F    = svp_pkg::FRAC_BITS;
    localparam int ND   = WORD;          // divider stages
    localparam int NS   = 7 + ND;        // t, seg, sq, prod, num, init, divs, out

    logic [NS-1:0] r_v, w_mv, w_vin, w_mv_nx;
    logic          w_en, w_in_fire;

    // Bubble-collapsing valid chain: a stage loads when the output moves or it is empty
    always_comb begin
        w_en      = !r_v[NS-1] || i_out_ready;
        w_mv      = {NS{w_en}} | ~r_v;
        w_in_fire = i_in_valid && w_mv[0];
        w_vin     = {r_v[NS-2:0], w_in_fire};
        w_mv_nx   = {1'b0, w_mv[NS-1:1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int i = 0; i < NS; i++) begin
                if (w_mv[i]) begin
                    r_v[i] <= w_vin[i];
                end else if (w_mv_nx[i]) begin
                    r_v[i] <= 1'b0;
                end
            end
        end
    end

    // Stage 0: sample time
    logic [WORD-1:0] r0_t;
    always_ff @(posedge i_clk) begin
        if (w_mv[0]) r0_t <= i_time;
    end

    // Stage 1: segment and distance into the segment
    svp_pkg::t_seg w1_seg, r1_seg;
    logic [TW-1:0] w1_t, w1_s;
    logic          w1_pos;
    always_comb begin
        w1_t   = TW'(r0_t[WORD-2:0]);
        w1_pos = !r0_t[WORD-1] && (r0_t != '0) && !i_prof.vzero;
        w1_seg = svp_pkg::SEG_NONE;
        w1_s   = '0;
        priority if (!w1_pos) begin
            w1_seg = svp_pkg::SEG_NONE;
        end else if (w1_t <= TW'(i_prof.half)) begin
            w1_seg = svp_pkg::SEG_RISE;
            w1_s   = w1_t;
        end else if (w1_t <= TW'(i_prof.x)) begin
            w1_seg = svp_pkg::SEG_APPROACH;
            w1_s   = TW'(i_prof.x) - w1_t;
        end else if (w1_t <= i_prof.tm_x) begin
            w1_seg = svp_pkg::SEG_CRUISE;
        end else if (w1_t <= i_prof.tm_half) begin
            w1_seg = svp_pkg::SEG_FALL;
            w1_s   = w1_t - i_prof.tm_x;
        end else if (w1_t <= i_prof.tm) begin
            w1_seg = svp_pkg::SEG_TAIL;
            w1_s   = i_prof.tm - w1_t;
        end else begin
            w1_seg = svp_pkg::SEG_NONE;
        end
    end

    logic [WORD-1:0] r1_s;
    always_ff @(posedge i_clk) begin
        if (w_mv[1]) begin
            r1_seg <= w1_seg;
            r1_s   <= w1_s[WORD-1:0];   // distance wraps to a word, as the square term takes it
        end
    end

    // Stage 2: s^2
    svp_pkg::t_seg     r2_seg;
    logic [2*WORD-1:0] r2_sq;
    always_ff @(posedge i_clk) begin
        if (w_mv[2]) begin
            r2_seg <= r1_seg;
            r2_sq  <= {{WORD{1'b0}}, r1_s} * {{WORD{1'b0}}, r1_s};
        end
    end

    // Stage 3: a times both halves of s^2
    svp_pkg::t_seg     r3_seg;
    logic [2*WORD-1:0] r3_pl, r3_ph;
    always_ff @(posedge i_clk) begin
        if (w_mv[3]) begin
            r3_seg <= r2_seg;
            r3_pl  <= {{WORD{1'b0}}, i_prof.accel} * {{WORD{1'b0}}, r2_sq[WORD-1:0]};
            r3_ph  <= {{WORD{1'b0}}, i_prof.accel} * {{WORD{1'b0}}, r2_sq[2*WORD-1:WORD]};
        end
    end

    // Stage 4: numerator a*s^2
    svp_pkg::t_seg   r4_seg;
    logic [NUMW-1:0] r4_num;
    always_ff @(posedge i_clk) begin
        if (w_mv[4]) begin
            r4_seg <= r3_seg;
            r4_num <= NUMW'(r3_pl) + {r3_ph, {WORD{1'b0}}};
        end
    end

    // Stage 5: saturation test, then one quotient bit per stage
    logic [REMW-1:0] w_den;
    assign w_den = REMW'({i_prof.x, {F{1'b0}}});

    svp_pkg::t_div   r_d [ND+1];
    logic [REMW-1:0] w_dd [ND];
    logic            w_ge [ND];

    // Trial divisor and compare of each divider stage
    always_comb begin
        for (int k = 0; k < ND; k++) begin
            w_dd[k] = w_den << (ND - 1 - k);
            w_ge[k] = {1'b0, r_d[k].rem} >= w_dd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv[5]) begin
            r_d[0].seg <= r4_seg;
            r_d[0].sat <= {1'b0, r4_num} >= (w_den << WORD);
            r_d[0].rem <= r4_num;
            r_d[0].q   <= '0;
        end
        for (int k = 0; k < ND; k++) begin
            if (w_mv[6 + k]) begin
                r_d[k+1].seg <= r_d[k].seg;
                r_d[k+1].sat <= r_d[k].sat;
                r_d[k+1].rem <= w_ge[k] ? (r_d[k].rem - w_dd[k][NUMW-1:0]) : r_d[k].rem;
                r_d[k+1].q   <= r_d[k].q | (WORD'(w_ge[k]) << (ND - 1 - k));
            end
        end
    end

    // Output stage: combine the square term with the cruise level
    logic [WORD-1:0] w_q, w_res, w_cru_sat, w_diff_sat;
    logic [CRW-1:0]  w_diff;
    always_comb begin
        if (i_prof.x == '0) begin
            w_q = '0;
        end else if (r_d[ND].sat) begin
            w_q = '1;
        end else begin
            w_q = r_d[ND].q;
        end
        w_cru_sat  = (i_prof.cruise[CRW-1:WORD] != '0) ? '1 : i_prof.cruise[WORD-1:0];
        w_diff     = i_prof.cruise - CRW'(w_q);
        w_diff_sat = (w_diff[CRW-1:WORD] != '0) ? '1 : w_diff[WORD-1:0];
        unique case (r_d[ND].seg)
            svp_pkg::SEG_RISE, svp_pkg::SEG_TAIL:
                w_res = w_q;
            svp_pkg::SEG_APPROACH, svp_pkg::SEG_FALL:
                w_res = (CRW'(w_q) > i_prof.cruise) ? '0 : w_diff_sat;
            svp_pkg::SEG_CRUISE:
                w_res = w_cru_sat;
            default:
                w_res = '0;
        endcase
    end

    logic [WORD-1:0] r_vel;
    always_ff @(posedge i_clk) begin
        if (w_mv[NS-1]) r_vel <= w_res;
    end

    assign o_in_ready  = w_mv[0];
    assign o_out_valid = r_v[NS-1];
    assign o_vel       = r_vel;

    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NS-2] && !r_d[ND].sat && i_prof.x != '0 |-> {1'b0, r_d[ND].rem} < w_den)
        else $error("square term remainder not below divisor");

    a_stage0_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] && !w_mv[1] |=> r_v[0])
        else $error("item lost from the first stage");

endmodule

>>> src/smooth_velocity_profile_core.sv
// Top level of the smooth velocity profile block: registers, setup and sample pipeline.
//
// One velocity item leaves for each sample_time item, in order, once it has passed
// the sample pipeline; a new sample can be taken every cycle unless the output
// stalls or setup runs, as the square-term divider is fully pipelined (one quotient
// bit per stage). After reset and after every configuration write the setup
// sequencer rederives the move constants (square root and two bit-serial
// divisions); i_in.ready stays low during that time.
module smooth_velocity_profile_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [svp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [svp_pkg::WORD-1:0]      i_cfg_wdata,
    svp_in_if.sink                        i_in,
    svp_out_if.source                     o_out
);
    localparam int WORD = svp_pkg::WORD;

    logic [WORD-1:0] r_dist, r_vel, r_accel;
    logic [WORD-1:0] w_accel;
    svp_pkg::t_profile w_prof;
    logic w_pipe_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist  <= svp_pkg::DISTANCE_RST;
            r_vel   <= svp_pkg::VELOCITY_RST;
            r_accel <= svp_pkg::ACCEL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                svp_pkg::REG_DISTANCE: r_dist  <= i_cfg_wdata;
                svp_pkg::REG_VELOCITY: r_vel   <= i_cfg_wdata;
                svp_pkg::REG_ACCEL:    r_accel <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Zero acceleration counts as one LSB
    assign w_accel = (r_accel == '0) ? WORD'(1) : r_accel;

    svp_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cfg_we),
        .i_dist  (r_dist),
        .i_vel   (r_vel),
        .i_accel (w_accel),
        .o_prof  (w_prof)
    );

    svp_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_prof      (w_prof),
        .i_in_valid  (i_in.valid && w_prof.ok),
        .o_in_ready  (w_pipe_ready),
        .i_time      (i_in.sample_time),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_vel       (o_out.velocity)
    );

    // Samples wait while the constants are rebuilt
    assign i_in.ready = w_pipe_ready && w_prof.ok;

    a_no_take_in_setup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_prof.ok |-> !i_in.ready)
        else $error("item taken while move constants are rebuilt");

endmodule
